>>> hw/rtl/kmer_window_minimizer_macros.svh
// Assertion macros for the k-mer window minimizer.
// Depends on nothing; included by kmer_window_minimizer.sv.
`ifndef KMER_WINDOW_MINIMIZER_MACROS_SVH
`define KMER_WINDOW_MINIMIZER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define KWM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define KWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/kwm_pkg.sv
// Shared types and constants for the k-mer window minimizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

   localparam int MAX_KMER_LENGTH = 32;
   localparam int MAX_WINDOW      = 32;

   localparam int KMER_W  = 2 * MAX_KMER_LENGTH;
   localparam int POS_W   = 32;
   localparam int LEN_W   = 6;
   localparam int CSR_IW  = 2;
   localparam int RING_AW = $clog2(MAX_WINDOW);

   localparam logic [CSR_IW-1:0] CSR_KMER_LENGTH  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_WINDOW_KMERS = 2'd1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PREP  = 7'b0000010,
      ST_SCAN  = 7'b0000100,
      ST_DRAIN = 7'b0001000,
      ST_EVAL  = 7'b0010000,
      ST_PUSH  = 7'b0100000,
      ST_FLUSH = 7'b1000000
   } state_type;

   // Clamp a raw register value to 1..hi.
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw,
                                                  input logic [LEN_W-1:0] hi);
      logic [LEN_W-1:0] r;
      if (raw == '0)     r = LEN_W'(1);
      else if (raw > hi) r = hi;
      else               r = raw;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kmer_window_minimizer.sv
// Top level of the k-mer window minimizer: sequencer, k-mer ring memory, one comparator.
// Depends on kwm_pkg and kmer_window_minimizer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "kmer_window_minimizer_macros.svh"

// Streams DNA one 2-bit base per req transfer (A<C<G<T) and packs the last k bases
// into a k-mer, first base most significant. From the k-th base on, each base yields
// the minimizer (smallest k-mer, earliest position on ties) of the newest
// min(w, k-mers seen) k-mers; on the base flagged stream_end the right-end
// minimizers of the newest n-1 down to 1 k-mers follow. A result is sent only when
// its (value, position) pair differs from the last one sent in this stream, and
// rsp_run_last marks the final result caused by a base. k-mers live in a 32-entry
// ring memory; one 64-bit comparator walks a window one entry per cycle. Steps: a
// base that forms no k-mer is accepted, prepared and finished; otherwise the prepare
// step writes the k-mer, the scan reads the window one ring entry at a time, a drain
// step covers the registered ring read and an evaluate step decides, before the
// finish step. The final base of a stream adds a scan, drain and evaluate for each
// right-end window, j = n-1 down to 1, plus a push step for each of its results
// before the last. Stalls on rsp_ready add cycles only when a
// result has to move into a still occupied rsp register. The window scan through
// the single read port of the ring sets the rate. req_ready is high only while the
// sequencer is idle; the last result of a base waits in the rsp register without
// holding off the next base, whose own results then wait behind it. Registers:
// index 0 is kmer_length, index 1 is window_kmers; 0 acts as 1, values above 32 act
// as 32, other indexes are ignored. Write them only between streams while the block
// is idle. Positions and the base count wrap at 2^32. After the final base the
// stream state clears so the next base starts a fresh stream.
module kmer_window_minimizer
   import kwm_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   // base input
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire  [1:0]                req_base,
   input  wire                       req_stream_end,
   // minimizer results
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic [KMER_W-1:0]         rsp_kmer_value,
   output logic [POS_W-1:0]          rsp_kmer_position,
   output logic                      rsp_run_last,
   // configuration writes
   input  wire                       csr_wr_en,
   input  wire  [CSR_IW-1:0]         csr_index,
   input  wire  [LEN_W-1:0]          csr_wdata
);

   // ---------------- registers ----------------
   state_type            state_ff, state_in;
   logic [LEN_W-1:0]     klen_ff, klen_in;
   logic [LEN_W-1:0]     wlen_ff, wlen_in;

   logic [KMER_W-1:0]    cur_ff, cur_in;        // packed current k-mer
   logic [POS_W-1:0]     bs_ff, bs_in;          // bases seen in this stream
   logic                 last_ff, last_in;      // this base ends the stream
   logic [POS_W-1:0]     newest_ff, newest_in;  // position of newest k-mer
   logic [LEN_W-1:0]     win_len_ff, win_len_in; // k-mers in the current window
   logic [LEN_W-1:0]     cnt_ff, cnt_in;        // scan counter, oldest first

   // read stage of the scan
   logic                 rd_valid_ff, rd_valid_in;
   logic                 rd_first_ff, rd_first_in;
   logic [POS_W-1:0]     rd_pos_ff, rd_pos_in;
   logic [KMER_W-1:0]    rd_data_ff;

   // running minimum
   logic [KMER_W-1:0]    min_val_ff, min_val_in;
   logic [POS_W-1:0]     min_pos_ff, min_pos_in;

   // dedup state
   logic                 sent_any_ff, sent_any_in;
   logic [KMER_W-1:0]    sent_val_ff, sent_val_in;
   logic [POS_W-1:0]     sent_pos_ff, sent_pos_in;

   // one result held back until we know whether another follows
   logic                 pend_valid_ff, pend_valid_in;
   logic [KMER_W-1:0]    pend_val_ff, pend_val_in;
   logic [POS_W-1:0]     pend_pos_ff, pend_pos_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [KMER_W-1:0]    out_val_ff, out_val_in;
   logic [POS_W-1:0]     out_pos_ff, out_pos_in;
   logic                 out_last_ff, out_last_in;

   // ring memory
   logic [KMER_W-1:0]    ring_mem [MAX_WINDOW];
   logic                 ring_we;
   logic [RING_AW-1:0]   ring_waddr;
   logic                 ring_re;
   logic [RING_AW-1:0]   ring_raddr;

   // ---------------- derived values ----------------
   logic [LEN_W-1:0]     k_eff, w_eff;
   logic [KMER_W-1:0]    kmer_mask;
   logic [POS_W-1:0]     newest_calc, count_calc;
   logic [LEN_W-1:0]     span_calc;
   logic [LEN_W-1:0]     scan_off;
   logic [POS_W-1:0]     scan_pos;
   logic                 out_free;
   logic                 is_dup;

   assign k_eff     = clamp_len(klen_ff, LEN_W'(MAX_KMER_LENGTH));
   assign w_eff     = clamp_len(wlen_ff, LEN_W'(MAX_WINDOW));
   // shift by 64 (k = 32) gives zero, so the mask becomes all ones
   assign kmer_mask = ~({KMER_W{1'b1}} << {k_eff, 1'b0});

   assign newest_calc = bs_ff - POS_W'(k_eff);
   assign count_calc  = newest_calc + POS_W'(1);
   assign span_calc   = ((count_calc == '0) || (count_calc > POS_W'(w_eff)))
                        ? w_eff : count_calc[LEN_W-1:0];

   assign scan_off = cnt_ff - LEN_W'(1);
   assign scan_pos = newest_ff - POS_W'(scan_off);

   assign out_free = !out_valid_ff || rsp_ready;
   assign is_dup   = sent_any_ff && (min_val_ff == sent_val_ff)
                     && (min_pos_ff == sent_pos_ff);

   assign ring_waddr = newest_calc[RING_AW-1:0];
   assign ring_raddr = scan_pos[RING_AW-1:0];

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = out_valid_ff;
   assign rsp_kmer_value    = out_val_ff;
   assign rsp_kmer_position = out_pos_ff;
   assign rsp_run_last      = out_last_ff;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      klen_in       = klen_ff;
      wlen_in       = wlen_ff;
      cur_in        = cur_ff;
      bs_in         = bs_ff;
      last_in       = last_ff;
      newest_in     = newest_ff;
      win_len_in    = win_len_ff;
      cnt_in        = cnt_ff;
      rd_valid_in   = 1'b0;
      rd_first_in   = 1'b0;
      rd_pos_in     = rd_pos_ff;
      min_val_in    = min_val_ff;
      min_pos_in    = min_pos_ff;
      sent_any_in   = sent_any_ff;
      sent_val_in   = sent_val_ff;
      sent_pos_in   = sent_pos_ff;
      pend_valid_in = pend_valid_ff;
      pend_val_in   = pend_val_ff;
      pend_pos_in   = pend_pos_ff;
      out_valid_in  = out_valid_ff;
      out_val_in    = out_val_ff;
      out_pos_in    = out_pos_ff;
      out_last_in   = out_last_ff;
      ring_we       = 1'b0;
      ring_re       = 1'b0;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         case (csr_index)
            CSR_KMER_LENGTH:  klen_in = csr_wdata;
            CSR_WINDOW_KMERS: wlen_in = csr_wdata;
            default:          ;
         endcase
      end

      // compare stage: strict less keeps the earliest (oldest) position on ties
      if (rd_valid_ff && (rd_first_ff || (rd_data_ff < min_val_ff))) begin
         min_val_in = rd_data_ff;
         min_pos_in = rd_pos_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in   = ((cur_ff << 2) | KMER_W'(req_base)) & kmer_mask;
               bs_in    = bs_ff + POS_W'(1);
               last_in  = req_stream_end;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (bs_ff >= POS_W'(k_eff)) begin
               ring_we    = 1'b1;
               newest_in  = newest_calc;
               win_len_in = span_calc;
               cnt_in     = span_calc;
               state_in   = ST_SCAN;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_SCAN: begin
            ring_re     = 1'b1;
            rd_valid_in = 1'b1;
            rd_first_in = (cnt_ff == win_len_ff);
            rd_pos_in   = scan_pos;
            cnt_in      = scan_off;
            if (cnt_ff == LEN_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!is_dup) begin
               sent_any_in = 1'b1;
               sent_val_in = min_val_ff;
               sent_pos_in = min_pos_ff;
            end
            if (!is_dup && pend_valid_ff) begin
               state_in = ST_PUSH;
            end else begin
               if (!is_dup) begin
                  pend_valid_in = 1'b1;
                  pend_val_in   = min_val_ff;
                  pend_pos_in   = min_pos_ff;
               end
               if (last_ff && (win_len_ff > LEN_W'(1))) begin
                  win_len_in = win_len_ff - LEN_W'(1);
                  cnt_in     = win_len_ff - LEN_W'(1);
                  state_in   = ST_SCAN;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_PUSH: begin
            // older pending result goes out, not the last of this base
            if (out_free) begin
               out_valid_in = 1'b1;
               out_val_in   = pend_val_ff;
               out_pos_in   = pend_pos_ff;
               out_last_in  = 1'b0;
               pend_val_in  = min_val_ff;
               pend_pos_in  = min_pos_ff;
               if (last_ff && (win_len_ff > LEN_W'(1))) begin
                  win_len_in = win_len_ff - LEN_W'(1);
                  cnt_in     = win_len_ff - LEN_W'(1);
                  state_in   = ST_SCAN;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in  = 1'b1;
                  out_val_in    = pend_val_ff;
                  out_pos_in    = pend_pos_ff;
                  out_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
               end
               if (last_ff) begin
                  cur_in      = '0;
                  bs_in       = '0;
                  sent_any_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         klen_ff       <= LEN_W'(15);
         wlen_ff       <= LEN_W'(10);
         cur_ff        <= '0;
         bs_ff         <= '0;
         last_ff       <= 1'b0;
         rd_valid_ff   <= 1'b0;
         sent_any_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         klen_ff       <= klen_in;
         wlen_ff       <= wlen_in;
         cur_ff        <= cur_in;
         bs_ff         <= bs_in;
         last_ff       <= last_in;
         rd_valid_ff   <= rd_valid_in;
         sent_any_ff   <= sent_any_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      newest_ff   <= newest_in;
      win_len_ff  <= win_len_in;
      cnt_ff      <= cnt_in;
      rd_first_ff <= rd_first_in;
      rd_pos_ff   <= rd_pos_in;
      min_val_ff  <= min_val_in;
      min_pos_ff  <= min_pos_in;
      sent_val_ff <= sent_val_in;
      sent_pos_ff <= sent_pos_in;
      pend_val_ff <= pend_val_in;
      pend_pos_ff <= pend_pos_in;
      out_val_ff  <= out_val_in;
      out_pos_ff  <= out_pos_in;
      out_last_ff <= out_last_in;
   end

   // ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_re) begin
         rd_data_ff <= ring_mem[ring_raddr];
      end
   end

   // ---------------- assertions ----------------
   `KWM_ASSERT_NOW(a_idle_no_pending, clock, reset, (state_ff == ST_IDLE), !pend_valid_ff, "held result left behind at idle")
   `KWM_ASSERT_NOW(a_scan_cnt_range, clock, reset, (state_ff == ST_SCAN), (cnt_ff >= LEN_W'(1)) && (cnt_ff <= win_len_ff) && (win_len_ff <= LEN_W'(MAX_WINDOW)), "scan counter out of window")
   `KWM_ASSERT_NOW(a_push_needs_pending, clock, reset, (state_ff == ST_PUSH), pend_valid_ff && sent_any_ff, "push without a held result")
   `KWM_ASSERT_NEXT(a_stream_clears, clock, reset, (state_ff == ST_FLUSH) && last_ff && (!pend_valid_ff || out_free), (bs_ff == '0) && !sent_any_ff && (state_ff == ST_IDLE), "stream state not cleared after final base")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for kmer_window_minimizer: directed table, then random streams.
// Depends on kwm_pkg and the kmer_window_minimizer RTL; no files or arguments.
`timescale 1ns / 1ps

module testbench;
   import kwm_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 10;
   // Covers the worst base: a stream end at w = 32 adds the right-end windows
   // over the newest j k-mers for j = 31..1 to the scan of the full window.
   localparam int SETTLE_CYCLES = 700;
   localparam int LIMIT_CYCLES  = 500000;
   localparam int RANDOM_BASES  = 320;
   localparam int QUIET_AFTER   = 270;
   localparam int MAX_PRINTED   = 30;
   localparam int NUM_FIXED     = 8;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   // Register indexes with no register behind them
   localparam logic [CSR_IW-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      logic [KMER_W-1:0] value;
      logic [POS_W-1:0]  position;
      logic              run_last;
   } minimizer_type;

   typedef enum {ROW_WRITE, ROW_BASE} row_kind_type;
   // CHK_MODEL: predictor decides; CHK_NONE: no transfer; CHK_ONE: one typed result
   typedef enum {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_type;

   typedef struct {
      row_kind_type      kind;
      logic [CSR_IW-1:0] sel;
      logic [LEN_W-1:0]  data;
      logic [1:0]        base;
      logic              tail;
      row_check_type     chk;
      logic [KMER_W-1:0] value;
      logic [POS_W-1:0]  position;
   } plan_row_type;

   // ---------------------------------------------------------------------------
   // DUT hookup
   // ---------------------------------------------------------------------------
   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_base;
   logic              req_stream_end;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [KMER_W-1:0] rsp_kmer_value;
   logic [POS_W-1:0]  rsp_kmer_position;
   logic              rsp_run_last;
   logic              csr_wr_en;
   logic [CSR_IW-1:0] csr_index;
   logic [LEN_W-1:0]  csr_wdata;

   kmer_window_minimizer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_base          (req_base),
      .req_stream_end    (req_stream_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kmer_value    (rsp_kmer_value),
      .rsp_kmer_position (rsp_kmer_position),
      .rsp_run_last      (rsp_run_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Predictor state: our own copy of the registers and stream state
   // ---------------------------------------------------------------------------
   logic [LEN_W-1:0]  k_raw;
   logic [LEN_W-1:0]  w_raw;
   logic [KMER_W-1:0] cur_kmer;
   logic [POS_W-1:0]  seen;
   logic [KMER_W-1:0] kmer_history [MAX_WINDOW];
   logic [KMER_W-1:0] sent_value;
   logic [POS_W-1:0]  sent_position;
   logic              sent_flag;

   minimizer_type pending_minimizers[$];
   minimizer_type step_results[$];
   plan_row_type  directed_plan[$];

   // Fixed settings walked first by the random part: extremes, out-of-range codes
   // (0 acts as 1, 63 acts as 32) and a few ordinary shapes.
   int unsigned fixed_k[NUM_FIXED] = '{1, 32, 0, 63, 2, 5, 15, 3};
   int unsigned fixed_w[NUM_FIXED] = '{1, 32, 63, 1, 5, 2, 10, 31};

   bit          quiet;
   bit          dirty;
   int          errors;
   int unsigned stall_left;
   int unsigned cycle_count;
   int unsigned bases_sent;
   int unsigned streams_sent;
   int unsigned writes_done;
   int unsigned results_checked;

   // ---------------------------------------------------------------------------
   // Clock and run limit
   // ---------------------------------------------------------------------------
   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d minimizers still due",
                  cycle_count, pending_minimizers.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------------
   task automatic note_mismatch(input string msg);
      errors++;
      if (errors <= MAX_PRINTED)
         $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // Register codes: zero behaves as one, anything past the maximum as the maximum
   function automatic int unsigned eff_len(input logic [LEN_W-1:0] raw,
                                          input int unsigned hi);
      if (raw == '0) return 1;
      if (raw > hi) return hi;
      return 32'(raw);
   endfunction

   function automatic logic [KMER_W-1:0] kmer_mask(input int unsigned k);
      if (k >= MAX_KMER_LENGTH) return '1;
      return (64'd1 << (2 * k)) - 64'd1;
   endfunction

   // Smallest of the newest j k-mers; walking oldest first with a strict compare
   // keeps the earliest position on a tie.
   task automatic window_min(input logic [POS_W-1:0] newest, input int unsigned j,
                             output logic [KMER_W-1:0] v, output logic [POS_W-1:0] p);
      logic [POS_W-1:0]  at;
      logic [KMER_W-1:0] cand;
      v = '0;
      p = '0;
      for (int t = j; t > 0; t--) begin
         at   = newest - POS_W'(t - 1);
         cand = kmer_history[at[RING_AW-1:0]];
         if (t == j || cand < v) begin
            v = cand;
            p = at;
         end
      end
   endtask

   // Repeats of the last sent (value, position) pair are dropped
   task automatic offer_minimizer(input logic [KMER_W-1:0] v, input logic [POS_W-1:0] p);
      minimizer_type m;
      if (sent_flag && v == sent_value && p == sent_position) return;
      m = '{value: v, position: p, run_last: 1'b0};
      step_results.insert(step_results.size(), m);
      sent_value    = v;
      sent_position = p;
      sent_flag     = 1'b1;
   endtask

   // Advance the predicted stream by one base; queue its minimizers when keep is set
   task automatic predict_minimizers(input logic [1:0] b, input logic tail, input bit keep);
      int unsigned       k_eff;
      int unsigned       w_eff;
      int unsigned       span;
      logic [POS_W-1:0]  newest;
      logic [POS_W-1:0]  count;
      logic [KMER_W-1:0] mv;
      logic [POS_W-1:0]  mp;
      k_eff = eff_len(k_raw, MAX_KMER_LENGTH);
      w_eff = eff_len(w_raw, MAX_WINDOW);
      step_results.delete();
      cur_kmer = ((cur_kmer << 2) | KMER_W'(b)) & kmer_mask(k_eff);
      seen     = seen + 1;
      if (seen >= k_eff) begin
         newest = seen - k_eff;
         count  = newest + 1;
         span   = (count == 0 || count > w_eff) ? w_eff : count;
         kmer_history[newest[RING_AW-1:0]] = cur_kmer;
         window_min(newest, span, mv, mp);
         offer_minimizer(mv, mp);
         // right end: shrinking windows over the newest span-1 .. 1 k-mers
         if (tail) begin
            for (int j = span - 1; j >= 1; j--) begin
               window_min(newest, j, mv, mp);
               offer_minimizer(mv, mp);
            end
         end
      end
      if (step_results.size() > 0)
         step_results[step_results.size() - 1].run_last = 1'b1;
      if (keep) begin
         foreach (step_results[i])
            pending_minimizers.insert(pending_minimizers.size(), step_results[i]);
      end
      if (tail) begin
         cur_kmer  = '0;
         seen      = '0;
         sent_flag = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Drivers: inputs move on the falling edge, transfers are seen on the rising edge
   // ---------------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_IW-1:0] sel, input logic [LEN_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = sel;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (sel == CSR_KMER_LENGTH)       k_raw = data;
      else if (sel == CSR_WINDOW_KMERS) w_raw = data;
      writes_done++;
   endtask

   task automatic send_base(input logic [1:0] b, input logic tail, input row_check_type chk,
                            input logic [KMER_W-1:0] tv, input logic [POS_W-1:0] tp);
      minimizer_type typed;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_base       = b;
      req_stream_end = tail;
      do @(posedge clock); while (!req_ready);
      predict_minimizers(b, tail, chk == CHK_MODEL);
      if (chk == CHK_ONE) begin
         typed = '{value: tv, position: tp, run_last: 1'b1};
         pending_minimizers.insert(pending_minimizers.size(), typed);
      end
      bases_sent++;
      if (tail) streams_sent++;
      dirty = 1'b1;
   endtask

   // Hold the sender off until every predicted minimizer has been transferred
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_minimizers.size() != 0) @(posedge clock);
   endtask

   // Idle point before register writes: drained, plus room for a base that
   // produced nothing but may still be scanning
   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      dirty = 1'b0;
   endtask

   task automatic plan_write(input logic [CSR_IW-1:0] sel, input logic [LEN_W-1:0] data);
      plan_row_type r;
      r = '{kind: ROW_WRITE, sel: sel, data: data, base: BASE_A, tail: 1'b0,
            chk: CHK_MODEL, value: '0, position: '0};
      directed_plan.insert(directed_plan.size(), r);
   endtask

   task automatic plan_base(input logic [1:0] b, input logic tail, input row_check_type chk,
                            input logic [KMER_W-1:0] v, input logic [POS_W-1:0] p);
      plan_row_type r;
      r = '{kind: ROW_BASE, sel: CSR_KMER_LENGTH, data: '0, base: b, tail: tail,
            chk: chk, value: v, position: p};
      directed_plan.insert(directed_plan.size(), r);
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random backpressure bursts, none in the quiet tail of the run
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Each transfer is matched against the oldest prediction, field by field
   always @(posedge clock) begin
      minimizer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (pending_minimizers.size() == 0) begin
            note_mismatch($sformatf("unexpected minimizer %h at position %0d",
                                    rsp_kmer_value, rsp_kmer_position));
         end else begin
            want = pending_minimizers.pop_front();
            if (rsp_kmer_value !== want.value)
               note_mismatch($sformatf("kmer_value %h, wanted %h",
                                       rsp_kmer_value, want.value));
            if (rsp_kmer_position !== want.position)
               note_mismatch($sformatf("kmer_position %0d, wanted %0d",
                                       rsp_kmer_position, want.position));
            if (rsp_run_last !== want.run_last)
               note_mismatch($sformatf("run_last %b, wanted %b at position %0d",
                                       rsp_run_last, want.run_last, want.position));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned kv;
      int unsigned wv;
      int unsigned kk;
      int unsigned ww;
      int unsigned full;
      int unsigned len;
      int unsigned flavor;
      int unsigned nstreams;
      int unsigned phase;
      int unsigned random_bases;
      logic [1:0]  b;
      logic [1:0]  prev;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_base       = BASE_A;
      req_stream_end = 1'b0;
      rsp_ready      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_KMER_LENGTH;
      csr_wdata      = '0;
      k_raw          = LEN_W'(15);
      w_raw          = LEN_W'(10);
      cur_kmer       = '0;
      seen           = '0;
      sent_value     = '0;
      sent_position  = '0;
      sent_flag      = 1'b0;
      foreach (kmer_history[i]) kmer_history[i] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed table --------------------------------------------------
      // reset defaults k=15, w=10: a one-base stream is shorter than k, nothing out
      plan_base(BASE_T, 1'b1, CHK_NONE, '0, '0);
      // k=1, w=1: every base is its own minimizer, all four codes
      plan_write(CSR_KMER_LENGTH, LEN_W'(1));
      plan_write(CSR_WINDOW_KMERS, LEN_W'(1));
      plan_base(BASE_A, 1'b0, CHK_ONE, 64'd0, 32'd0);
      plan_base(BASE_T, 1'b0, CHK_ONE, 64'd3, 32'd1);
      plan_base(BASE_G, 1'b0, CHK_ONE, 64'd2, 32'd2);
      plan_base(BASE_C, 1'b1, CHK_ONE, 64'd1, 32'd3);
      // zero codes act as one
      plan_write(CSR_KMER_LENGTH, LEN_W'(0));
      plan_write(CSR_WINDOW_KMERS, LEN_W'(0));
      plan_base(BASE_T, 1'b0, CHK_ONE, 64'd3, 32'd0);
      plan_base(BASE_T, 1'b1, CHK_ONE, 64'd3, 32'd1);
      // writes to unused indexes are dropped, so k and w stay at one
      plan_write(CSR_SPARE_2, LEN_W'(63));
      plan_write(CSR_SPARE_3, LEN_W'(63));
      plan_base(BASE_G, 1'b1, CHK_ONE, 64'd2, 32'd0);
      // k=2, w above range: TT then TA, end window repeats the last pair
      plan_write(CSR_KMER_LENGTH, LEN_W'(2));
      plan_write(CSR_WINDOW_KMERS, LEN_W'(63));
      plan_base(BASE_T, 1'b0, CHK_NONE, '0, '0);
      plan_base(BASE_T, 1'b0, CHK_ONE, 64'd15, 32'd0);
      plan_base(BASE_A, 1'b1, CHK_MODEL, '0, '0);
      // k=1, w=2: equal k-mers, earliest wins and the repeat is suppressed
      plan_write(CSR_KMER_LENGTH, LEN_W'(1));
      plan_write(CSR_WINDOW_KMERS, LEN_W'(2));
      plan_base(BASE_C, 1'b0, CHK_MODEL, '0, '0);
      plan_base(BASE_C, 1'b0, CHK_MODEL, '0, '0);
      plan_base(BASE_A, 1'b1, CHK_MODEL, '0, '0);
      // k above range clamps to 32: three bases give no k-mer
      plan_write(CSR_KMER_LENGTH, LEN_W'(63));
      plan_write(CSR_WINDOW_KMERS, LEN_W'(32));
      plan_base(BASE_G, 1'b0, CHK_NONE, '0, '0);
      plan_base(BASE_T, 1'b0, CHK_NONE, '0, '0);
      plan_base(BASE_C, 1'b1, CHK_NONE, '0, '0);
      // k=1, w=32 on a short stream: several right-end minimizers in one step
      plan_write(CSR_KMER_LENGTH, LEN_W'(1));
      plan_base(BASE_A, 1'b0, CHK_MODEL, '0, '0);
      plan_base(BASE_C, 1'b0, CHK_MODEL, '0, '0);
      plan_base(BASE_G, 1'b0, CHK_MODEL, '0, '0);
      plan_base(BASE_T, 1'b1, CHK_MODEL, '0, '0);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_WRITE) begin
            if (dirty) settle();
            write_reg(directed_plan[i].sel, directed_plan[i].data);
         end else begin
            send_base(directed_plan[i].base, directed_plan[i].tail, directed_plan[i].chk,
                      directed_plan[i].value, directed_plan[i].position);
         end
      end

      // --- random streams --------------------------------------------------
      // Each phase settles, writes both registers, then sends whole streams.
      // Most streams are at least k+w-1 long so the interior windows get exercised;
      // about one in five is cut short to hit the left/right-end shortcuts.
      phase        = 0;
      random_bases = 0;
      while (random_bases < RANDOM_BASES) begin
         if (phase < NUM_FIXED) begin
            kv       = fixed_k[phase];
            wv       = fixed_w[phase];
            nstreams = 1;
         end else begin
            kv       = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 10);
            wv       = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 16);
            nstreams = $urandom_range(1, 2);
         end
         if (dirty) settle();
         write_reg(CSR_KMER_LENGTH, LEN_W'(kv));
         write_reg(CSR_WINDOW_KMERS, LEN_W'(wv));
         kk   = eff_len(LEN_W'(kv), MAX_KMER_LENGTH);
         ww   = eff_len(LEN_W'(wv), MAX_WINDOW);
         full = kk + ww - 1;

         repeat (nstreams) begin
            if (full > 1 && $urandom_range(0, 4) == 0)
               len = $urandom_range(1, full - 1);
            else
               len = full + $urandom_range(0, 6);
            flavor = $urandom_range(0, 3);
            prev   = 2'($urandom_range(0, 3));
            for (int n = 0; n < len; n++) begin
               case (flavor)
                  0: b = 2'($urandom_range(0, 1));      // A/C only: many close k-mers
                  1: b = ($urandom_range(0, 3) != 0) ? prev : 2'($urandom_range(0, 3));
                  default: b = 2'($urandom_range(0, 3));
               endcase
               // occasional hold-off until the result side has caught up
               if (!quiet && $urandom_range(0, 39) == 0) wait_drained();
               send_base(b, n == len - 1, CHK_MODEL, '0, '0);
               prev = b;
               random_bases++;
               if (random_bases >= QUIET_AFTER) quiet = 1'b1;
            end
         end
         phase++;
      end

      settle();

      $display("Sent %0d bases in %0d streams with %0d register writes (k and w from 1 to 32,",
               bases_sent, streams_sent, writes_done);
      $display("  zero and over-range codes, short streams); %0d minimizer transfers checked.",
               results_checked);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
